>>> hdl/mvsp_pkg.sv
`default_nettype none
package mvsp_pkg;

  // Fixed configuration of the player.
  localparam int PADS             = 32;
  localparam int FRAMES_PER_VOICE = 4096;
  localparam int SAMPLE_BITS      = 16;

  localparam int NUM_VOICES  = PADS + 1;
  localparam int VOICE_W     = $clog2(NUM_VOICES);
  localparam int CNT_W       = $clog2(NUM_VOICES + 1);
  localparam int POS_W       = $clog2(FRAMES_PER_VOICE + 1);
  localparam int FRAME_W     = $clog2(FRAMES_PER_VOICE);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int STORE_DEPTH = NUM_VOICES * FRAMES_PER_VOICE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // The divider works on the left and right sums side by side.
  localparam int LANES      = 2;
  localparam int LANE_L     = 0;
  localparam int LANE_R     = 1;
  localparam int DIV_STEP_W = $clog2(SUM_W);

  localparam logic [3:0] MIDI_NOTE_ON = 4'h9;

  typedef enum logic [2:0] {
    MODE_BEGIN   = 3'd0,
    MODE_FRAME   = 3'd1,
    MODE_END     = 3'd2,
    MODE_MIDI    = 3'd3,
    MODE_RESTART = 3'd4,
    MODE_TICK    = 3'd5
  } mode_e;

endpackage
`default_nettype wire

>>> hdl/mvsp_div.sv
`default_nettype none
module mvsp_div
  import mvsp_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [LANES-1:0][SUM_W-1:0]     num_i,
  input  logic [CNT_W-1:0]                den_i,
  output logic                            done_o,
  output logic [LANES-1:0][SUM_W-1:0]     quo_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [DIV_STEP_W-1:0]         step_q;
  logic [CNT_W-1:0]              den_q;
  logic [LANES-1:0]              neg_q;
  logic [LANES-1:0][SUM_W-1:0]   dq_q;
  logic [LANES-1:0][CNT_W-1:0]   rem_q;
  logic [LANES-1:0][SUM_W-1:0]   quo_q;

  logic [LANES-1:0][CNT_W:0]     rem_sh;
  logic [LANES-1:0]              fits;
  logic [LANES-1:0][CNT_W-1:0]   rem_nx;
  logic [LANES-1:0][SUM_W-1:0]   dq_nx;
  logic                          last_step;

  // One quotient bit per lane and cycle, restoring form on magnitudes.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rem_sh[k] = {rem_q[k], dq_q[k][SUM_W-1]};
      fits[k]   = rem_sh[k] >= {1'b0, den_q};
      rem_nx[k] = fits[k] ? CNT_W'(rem_sh[k] - {1'b0, den_q}) : rem_sh[k][CNT_W-1:0];
      dq_nx[k]  = {dq_q[k][SUM_W-2:0], fits[k]};
    end
  end

  assign last_step = !start_i && busy_q && (step_q == DIV_STEP_W'(SUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      den_q  <= '0;
      neg_q  <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        den_q  <= den_i;
        for (int k = 0; k < LANES; k++) begin
          neg_q[k] <= num_i[k][SUM_W-1];
          dq_q[k]  <= num_i[k][SUM_W-1] ? SUM_W'(-num_i[k]) : num_i[k];
          rem_q[k] <= '0;
        end
      end else if (busy_q) begin
        step_q <= step_q + DIV_STEP_W'(1);
        for (int k = 0; k < LANES; k++) begin
          dq_q[k]  <= dq_nx[k];
          rem_q[k] <= rem_nx[k];
        end
        if (last_step) begin
          busy_q <= 1'b0;
          for (int k = 0; k < LANES; k++) begin
            quo_q[k] <= neg_q[k] ? SUM_W'(-dq_nx[k]) : dq_nx[k];
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

>>> hdl/multi_voice_sample_player_mixer_top.sv
// Load, end-load, MIDI and restart beats are accepted, then do one read-modify-write
// of the voice state memory. Ignored beats keep the block idle.
// A tick's result is registered after a voice sweep, then a divider. The next
// beat is accepted in the cycle after that, later while a result waits.
// Reset (asynchronous, active low) clears all voices to silent and empty.
`default_nettype none
module multi_voice_sample_player_mixer_top
  import mvsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [5:0]  voice_i,
  input  logic [15:0] left_in_i,
  input  logic [15:0] right_in_i,
  input  logic [7:0]  midi_status_i,
  input  logic [7:0]  midi_note_i,
  input  logic [4:0]  pad_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_out_o,
  output logic [15:0] right_out_o,
  output logic [5:0]  active_count_o
);

  // Per-voice state word. An entry whose valid bit is clear reads as all zero,
  // which is the reset state of a voice.
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] fill;
  } voice_st_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] l;
    logic [SAMPLE_BITS-1:0] r;
  } frame_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_TICK,
    S_DIV,
    S_OUT
  } state_e;

  function automatic logic [ADDR_W-1:0] smp_addr(input logic [VOICE_W-1:0] v,
                                                  input logic [FRAME_W-1:0] f);
    smp_addr = ADDR_W'(int'(v) * FRAMES_PER_VOICE + int'(f));
  endfunction

  // Memories: voice state (one entry per voice) and the sample store.
  voice_st_t st_mem  [NUM_VOICES];
  frame_t    smp_mem [STORE_DEPTH];

  state_e                 state_q;
  mode_e                  op_q;
  logic [VOICE_W-1:0]     voice_q;
  logic [SAMPLE_BITS-1:0] ld_left_q;
  logic [SAMPLE_BITS-1:0] ld_right_q;
  logic [NUM_VOICES-1:0]  st_vld_q;
  logic                   rd_vld_q;
  voice_st_t              st_rdata_q;
  frame_t                 smp_rdata_q;

  // Tick sweep: stage one holds a state word, stage two a sample frame.
  logic [CNT_W-1:0]       tk_idx_q;
  logic                   s1_vld_q;
  logic [VOICE_W-1:0]     s1_voice_q;
  logic                   s2_vld_q;
  logic [SUM_W-1:0]       sum_l_q;
  logic [SUM_W-1:0]       sum_r_q;
  logic [CNT_W-1:0]       cnt_q;

  logic                   out_vld_q;
  logic [15:0]            out_left_q;
  logic [15:0]            out_right_q;
  logic [5:0]             out_cnt_q;
  logic                   out_load;

  logic                   in_acc;
  mode_e                  in_mode;
  logic [VOICE_W-1:0]     tgt;
  logic                   tgt_ok;
  voice_st_t              cur;

  logic [VOICE_W-1:0]     st_raddr;
  logic                   st_we;
  logic [VOICE_W-1:0]     st_waddr;
  voice_st_t              st_wdata;
  logic [ADDR_W-1:0]      smp_raddr;
  logic                   smp_we;
  logic [ADDR_W-1:0]      smp_waddr;
  frame_t                 smp_wdata;
  logic                   tk_act;

  logic                          div_start;
  logic                          div_done;
  logic [LANES-1:0][SUM_W-1:0]   div_num;
  logic [LANES-1:0][SUM_W-1:0]   div_quo;
  logic [CNT_W-1:0]              div_den;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_mode    = mode_e'(mode_i);
  assign cur        = rd_vld_q ? st_rdata_q : '0;

  // The output register takes a finished result once it is free.
  assign out_load   = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);

  // Target voice of a non-tick beat, and whether the beat does anything.
  always_comb begin
    tgt    = '0;
    tgt_ok = 1'b0;
    case (in_mode)
      MODE_BEGIN, MODE_FRAME, MODE_END: begin
        tgt    = VOICE_W'(voice_i);
        tgt_ok = {1'b0, voice_i} < 7'(NUM_VOICES);
      end
      MODE_MIDI: begin
        tgt    = VOICE_W'(midi_note_i) + VOICE_W'(1);
        tgt_ok = (midi_status_i[7:4] == MIDI_NOTE_ON) && ({1'b0, midi_note_i} < 9'(PADS));
      end
      MODE_RESTART: begin
        tgt    = VOICE_W'(pad_index_i) + VOICE_W'(1);
        tgt_ok = {2'b0, pad_index_i} < 7'(PADS);
      end
      default: begin
        tgt    = '0;
        tgt_ok = 1'b0;
      end
    endcase
  end

  // Memory port control. Only one item is in flight, and during a tick the
  // entry written back is always one behind the entry being read, so reads
  // and writes never meet on the same entry.
  always_comb begin
    st_raddr  = '0;
    st_we     = 1'b0;
    st_waddr  = voice_q;
    st_wdata  = cur;
    smp_raddr = '0;
    smp_we    = 1'b0;
    smp_waddr = '0;
    smp_wdata = '{l: ld_left_q, r: ld_right_q};
    tk_act    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_mode != MODE_TICK) begin
          st_raddr = tgt;
        end
      end
      S_WR: begin
        st_we = 1'b1;
        case (op_q)
          MODE_BEGIN: st_wdata = '0;
          MODE_FRAME: begin
            // Frames past the end of the voice's store are dropped.
            if (cur.fill < POS_W'(FRAMES_PER_VOICE)) begin
              smp_we        = 1'b1;
              smp_waddr     = smp_addr(voice_q, FRAME_W'(cur.fill));
              st_wdata.fill = cur.fill + POS_W'(1);
            end
          end
          MODE_END: begin
            // The generated track starts at once; a pad parks at its end.
            st_wdata.len = cur.fill;
            st_wdata.pos = (voice_q == '0) ? '0 : cur.fill;
          end
          MODE_MIDI, MODE_RESTART: st_wdata.pos = '0;
          default: st_we = 1'b0;
        endcase
      end
      S_TICK: begin
        if (tk_idx_q < CNT_W'(NUM_VOICES)) begin
          st_raddr = VOICE_W'(tk_idx_q);
        end
        tk_act = s1_vld_q && (cur.pos < cur.len) && (cur.pos < POS_W'(FRAMES_PER_VOICE));
        if (tk_act) begin
          smp_raddr    = smp_addr(s1_voice_q, FRAME_W'(cur.pos));
          st_we        = 1'b1;
          st_waddr     = s1_voice_q;
          st_wdata.pos = cur.pos + POS_W'(1);
        end
        div_start = !s1_vld_q && !s2_vld_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    st_rdata_q  <= st_mem[st_raddr];
    smp_rdata_q <= smp_mem[smp_raddr];
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (smp_we) begin
      smp_mem[smp_waddr] <= smp_wdata;
    end
  end

  assign div_num[LANE_L] = sum_l_q;
  assign div_num[LANE_R] = sum_r_q;
  assign div_den         = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

  mvsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= MODE_BEGIN;
      voice_q     <= '0;
      ld_left_q   <= '0;
      ld_right_q  <= '0;
      st_vld_q    <= '0;
      rd_vld_q    <= 1'b0;
      tk_idx_q    <= '0;
      s1_vld_q    <= 1'b0;
      s1_voice_q  <= '0;
      s2_vld_q    <= 1'b0;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      cnt_q       <= '0;
      out_vld_q   <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_cnt_q   <= '0;
    end else begin
      rd_vld_q <= st_vld_q[st_raddr];
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q       <= in_mode;
            voice_q    <= tgt;
            ld_left_q  <= left_in_i[SAMPLE_BITS-1:0];
            ld_right_q <= right_in_i[SAMPLE_BITS-1:0];
            if (in_mode == MODE_TICK) begin
              // Voice zero's state read is issued in this cycle.
              state_q    <= S_TICK;
              tk_idx_q   <= CNT_W'(1);
              s1_vld_q   <= 1'b1;
              s1_voice_q <= '0;
              s2_vld_q   <= 1'b0;
              sum_l_q    <= '0;
              sum_r_q    <= '0;
              cnt_q      <= '0;
            end else if (tgt_ok) begin
              state_q <= S_WR;
            end
          end
        end
        S_WR: state_q <= S_IDLE;
        S_TICK: begin
          if (tk_idx_q < CNT_W'(NUM_VOICES)) begin
            s1_vld_q   <= 1'b1;
            s1_voice_q <= VOICE_W'(tk_idx_q);
            tk_idx_q   <= tk_idx_q + CNT_W'(1);
          end else begin
            s1_vld_q <= 1'b0;
          end
          s2_vld_q <= tk_act;
          if (s2_vld_q) begin
            sum_l_q <= sum_l_q + {{(SUM_W - SAMPLE_BITS){smp_rdata_q.l[SAMPLE_BITS-1]}},
                                  smp_rdata_q.l};
            sum_r_q <= sum_r_q + {{(SUM_W - SAMPLE_BITS){smp_rdata_q.r[SAMPLE_BITS-1]}},
                                  smp_rdata_q.r};
            cnt_q   <= cnt_q + CNT_W'(1);
          end
          if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_left_q  <= 16'(div_quo[LANE_L]);
            out_right_q <= 16'(div_quo[LANE_R]);
            out_cnt_q   <= 6'(cnt_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign left_out_o     = out_left_q;
  assign right_out_o    = out_right_q;
  assign active_count_o = out_cnt_q;

endmodule
`default_nettype wire

>>> hdl/mvsp_checker.sv
`default_nettype none
module mvsp_checker
  import mvsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] left_out_o,
  input logic [15:0] right_out_o,
  input logic [5:0]  active_count_o
);

  // A result waiting on a stalled consumer is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_out_o) &&
      $stable(right_out_o) && $stable(active_count_o))
    else $error("result changed while stalled");

  // An accepted tick keeps the input side busy in the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_TICK |=> in_stall_o)
    else $error("input not stalled after tick");

  // Only a tick ever produces a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i != MODE_TICK |=> !$rose(out_valid_o))
    else $error("result after a non-tick beat");

  // A tick with no active voice is silent.
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_count_o == '0 |-> left_out_o == '0 && right_out_o == '0)
    else $error("silent tick with nonzero output");

endmodule

bind multi_voice_sample_player_mixer_top mvsp_checker u_mvsp_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mvsp_pkg::*;

  // Mode codes that the package leaves unnamed. The block must ignore them.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

  localparam int RANDOM_BEATS     = 1850;
  localparam int LONG_HOLD_AT     = 900;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 100;
  localparam int REPORT_LIMIT     = 10;

  // One input beat. The drain flag marks a point in the stream where the
  // sender stops until every mix owed so far has come back.
  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  voice;
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  status;
    logic [7:0]  note;
    logic [4:0]  pad;
    logic        drain;
  } beat_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [5:0]  voices;
  } mix_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i        = '0;
  logic [5:0]  voice_i       = '0;
  logic [15:0] left_in_i     = '0;
  logic [15:0] right_in_i    = '0;
  logic [7:0]  midi_status_i = '0;
  logic [7:0]  midi_note_i   = '0;
  logic [4:0]  pad_index_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [15:0] left_out_o;
  logic [15:0] right_out_o;
  logic [5:0]  active_count_o;

  multi_voice_sample_player_mixer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .voice_i        (voice_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .midi_status_i  (midi_status_i),
    .midi_note_i    (midi_note_i),
    .pad_index_i    (pad_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .active_count_o (active_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the player: the stored frames of every voice, plus the
  // published length, the play position and the fill count of each load.
  logic signed [SAMPLE_BITS-1:0] pcm_left  [NUM_VOICES][FRAMES_PER_VOICE];
  logic signed [SAMPLE_BITS-1:0] pcm_right [NUM_VOICES][FRAMES_PER_VOICE];
  int track_len  [NUM_VOICES];
  int track_pos  [NUM_VOICES];
  int track_fill [NUM_VOICES];

  beat_t stim_queue[$];   // beats still to be offered, in order
  mix_t  mix_queue[$];    // mixes owed by the block, oldest first
  beat_t beat_on_bus;     // the beat currently driven on the input ports

  int beats_sent    = 0;
  int beats_taken   = 0;
  int results_taken = 0;
  int results_seen  = 0;
  int mixes_checked = 0;
  int err_count     = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int recv_wait     = 0;
  int recv_calm     = 0;
  logic hold_results = 1'b0;

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Apply one accepted beat to the player copy. A tick walks every voice,
  // sums the frames of those that sound, divides by their number (or by one
  // when none sounds) truncating toward zero, and owes one mix.
  task automatic advance_player(input beat_t b);
    int v;
    int sum_l;
    int sum_r;
    int sounding;
    int div;
    mix_t m;
    case (b.mode)
      MODE_BEGIN: begin
        if (b.voice < NUM_VOICES) begin
          track_len[b.voice]  = 0;
          track_pos[b.voice]  = 0;
          track_fill[b.voice] = 0;
        end
      end
      MODE_FRAME: begin
        if (b.voice < NUM_VOICES && track_fill[b.voice] < FRAMES_PER_VOICE) begin
          pcm_left[b.voice][track_fill[b.voice]]  = b.left;
          pcm_right[b.voice][track_fill[b.voice]] = b.right;
          track_fill[b.voice] = track_fill[b.voice] + 1;
        end
      end
      MODE_END: begin
        if (b.voice < NUM_VOICES) begin
          track_len[b.voice] = track_fill[b.voice];
          // The generated track starts at once; a pad waits at its end.
          track_pos[b.voice] = (b.voice == 0) ? 0 : track_len[b.voice];
        end
      end
      MODE_MIDI: begin
        if (b.status[7:4] == MIDI_NOTE_ON && b.note < PADS) track_pos[b.note + 1] = 0;
      end
      MODE_RESTART: begin
        if (b.pad < PADS) track_pos[b.pad + 1] = 0;
      end
      MODE_TICK: begin
        sum_l    = 0;
        sum_r    = 0;
        sounding = 0;
        for (v = 0; v < NUM_VOICES; v++) begin
          if (track_pos[v] < track_len[v] && track_pos[v] < FRAMES_PER_VOICE) begin
            sum_l = sum_l + pcm_left[v][track_pos[v]];
            sum_r = sum_r + pcm_right[v][track_pos[v]];
            track_pos[v] = track_pos[v] + 1;
            sounding++;
          end
        end
        div      = (sounding == 0) ? 1 : sounding;
        m.left   = 16'(sum_l / div);
        m.right  = 16'(sum_r / div);
        m.voices = 6'(sounding);
        mix_queue = {mix_queue, m};
      end
      default: ;
    endcase
  endtask

  task automatic add_beat(input beat_t b);
    stim_queue = {stim_queue, b};
  endtask

  // Stimulus helpers. Fields that a mode does not use carry random noise.
  function automatic beat_t noise_beat(input logic [2:0] mode);
    beat_t b;
    b.mode   = mode;
    b.voice  = 6'($urandom);
    b.left   = 16'($urandom);
    b.right  = 16'($urandom);
    b.status = 8'($urandom);
    b.note   = 8'($urandom);
    b.pad    = 5'($urandom);
    b.drain  = 1'b0;
    return b;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_exact(input logic [2:0] mode, input int voice, input logic [15:0] left,
                             input logic [15:0] right, input logic [7:0] status,
                             input logic [7:0] note, input int pad);
    beat_t b;
    b.mode   = mode;
    b.voice  = 6'(voice);
    b.left   = left;
    b.right  = right;
    b.status = status;
    b.note   = note;
    b.pad    = 5'(pad);
    b.drain  = 1'b0;
    add_beat(b);
  endtask

  task automatic queue_drain();
    beat_t b;
    b       = '0;
    b.drain = 1'b1;
    add_beat(b);
  endtask

  // A well-formed load: begin, a run of frames, end.
  task automatic queue_load(input int voice, input int frames);
    beat_t b;
    int k;
    b       = noise_beat(MODE_BEGIN);
    b.voice = 6'(voice);
    add_beat(b);
    for (k = 0; k < frames; k++) begin
      b       = noise_beat(MODE_FRAME);
      b.voice = 6'(voice);
      b.left  = pick_sample();
      b.right = pick_sample();
      add_beat(b);
    end
    b       = noise_beat(MODE_END);
    b.voice = 6'(voice);
    add_beat(b);
  endtask

  task automatic queue_note_on(input int pad);
    beat_t b;
    b             = noise_beat(MODE_MIDI);
    b.status[7:4] = MIDI_NOTE_ON;
    b.note        = 8'(pad);
    add_beat(b);
  endtask

  // Input side. Inputs change on the falling edge only. A new beat is put
  // up once the previous one has been taken (the taken count catches up
  // with the sent count) and the gap drawn for it has run out. Gaps are
  // drawn at random, with the occasional run of back-to-back beats.
  always @(negedge clk_i) begin : sender
    beat_t nxt;
    if (rst_ni && (!in_valid_i || beats_taken == beats_sent)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (stim_queue.size() != 0 && stim_queue[0].drain) begin
        // Hold back until every mix owed so far has been checked.
        in_valid_i <= 1'b0;
        if (mix_queue.size() == 0) stim_queue.delete(0);
      end else if (stim_queue.size() != 0) begin
        nxt = stim_queue.pop_front();
        mode_i        <= nxt.mode;
        voice_i       <= nxt.voice;
        left_in_i     <= nxt.left;
        right_in_i    <= nxt.right;
        midi_status_i <= nxt.status;
        midi_note_i   <= nxt.note;
        pad_index_i   <= nxt.pad;
        beat_on_bus   <= nxt;
        in_valid_i    <= 1'b1;
        beats_sent = beats_sent + 1;
        if (send_calm != 0) begin
          send_gap  = 0;
          send_calm = send_calm - 1;
        end else if ($urandom_range(0, 31) == 0) begin
          send_gap  = 0;
          send_calm = $urandom_range(20, 80);
        end else begin
          send_gap = $urandom_range(0, 3);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side. For each mix a random stall is drawn; the stall goes up
  // right away, often before the mix shows, and counts down only while a
  // mix is waiting. The long hold overrides it.
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        if (recv_calm != 0) begin
          recv_wait = 0;
          recv_calm = recv_calm - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_wait = 0;
          recv_calm = $urandom_range(10, 40);
        end else begin
          recv_wait = $urandom_range(0, 3);
        end
      end
      out_stall_i <= hold_results || (recv_wait != 0);
      if (out_valid_o && recv_wait != 0) recv_wait = recv_wait - 1;
    end
  end

  // Both handshakes are sampled on the rising edge. The outgoing mix is
  // checked before the incoming beat is applied, since a mix leaving in this
  // cycle always belongs to a tick taken earlier.
  always @(posedge clk_i) begin : result_check
    mix_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_taken <= results_taken + 1;
        if (mix_queue.size() == 0) begin
          report_error($sformatf("unexpected mix: left %0d right %0d voices %0d",
                                 $signed(left_out_o), $signed(right_out_o), active_count_o));
        end else begin
          want = mix_queue.pop_front();
          if (left_out_o !== want.left)
            report_error($sformatf("mix %0d left: expected %0d, got %0d", mixes_checked,
                                   $signed(want.left), $signed(left_out_o)));
          if (right_out_o !== want.right)
            report_error($sformatf("mix %0d right: expected %0d, got %0d", mixes_checked,
                                   $signed(want.right), $signed(right_out_o)));
          if (active_count_o !== want.voices)
            report_error($sformatf("mix %0d voices: expected %0d, got %0d", mixes_checked,
                                   want.voices, active_count_o));
          mixes_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        beats_taken <= beats_taken + 1;
        advance_player(beat_on_bus);
      end
    end
  end

  // Once the run is well into the random part, the receiver refuses mixes
  // for a long stretch. The sender keeps offering beats, so the block ends
  // up holding a finished mix and must stall its input.
  initial begin : long_hold
    while (beats_taken < LONG_HOLD_AT) @(posedge clk_i);
    hold_results = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    hold_results = 1'b0;
  end

  initial begin : stimulus
    beat_t b;
    int v;
    int k;
    int pick;

    for (v = 0; v < NUM_VOICES; v++) begin
      track_len[v]  = 0;
      track_pos[v]  = 0;
      track_fill[v] = 0;
    end

    // Directed part. Frames without a prior begin go to a pad whose fill
    // count starts at zero; ending that load leaves the pad parked, so the
    // first tick is silent.
    queue_exact(MODE_FRAME, 2, 16'h7fff, 16'h8000, 8'h00, 8'h00, 0);
    queue_exact(MODE_END, 2, 16'h0000, 16'h0000, 8'hff, 8'hff, 31);
    queue_exact(MODE_TICK, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_BEGIN, 1, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_FRAME, 1, 16'h8000, 16'h7fff, 8'h00, 8'h00, 0);
    queue_exact(MODE_FRAME, 1, 16'hffff, 16'h0001, 8'h00, 8'h00, 0);
    queue_exact(MODE_END, 1, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    // A note-off must not trigger; note-ons for notes 0 and 1 start pads.
    queue_exact(MODE_MIDI, 0, 16'h0000, 16'h0000, {MIDI_NOTE_OFF, 4'h0}, 8'h00, 0);
    queue_exact(MODE_MIDI, 0, 16'h0000, 16'h0000, {MIDI_NOTE_ON, 4'h0}, 8'h00, 0);
    queue_exact(MODE_MIDI, 0, 16'h0000, 16'h0000, {MIDI_NOTE_ON, 4'hf}, 8'h01, 0);
    // The generated track starts from its first frame as soon as its load ends.
    queue_exact(MODE_BEGIN, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_FRAME, 0, 16'h7fff, 16'h7fff, 8'h00, 8'h00, 0);
    queue_exact(MODE_FRAME, 0, 16'h7fff, 16'h8000, 8'h00, 8'h00, 0);
    queue_exact(MODE_END, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_TICK, 63, 16'hffff, 16'hffff, 8'hff, 8'hff, 31);
    // Notes at or above the pad count are ignored; restarting an empty pad
    // keeps it silent.
    queue_exact(MODE_MIDI, 0, 16'h0000, 16'h0000, {MIDI_NOTE_ON, 4'h0}, 8'd32, 0);
    queue_exact(MODE_MIDI, 0, 16'h0000, 16'h0000, {MIDI_NOTE_ON, 4'h0}, 8'hff, 0);
    queue_exact(MODE_RESTART, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 31);
    queue_exact(MODE_RESTART, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    // Load beats for voices past the last pad and the unused modes do nothing.
    queue_exact(MODE_BEGIN, 63, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_FRAME, 33, 16'h1234, 16'h4321, 8'h00, 8'h00, 0);
    queue_exact(MODE_END, 40, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_SPARE_A, 1, 16'hffff, 16'hffff, 8'h90, 8'h00, 0);
    queue_exact(MODE_SPARE_B, 0, 16'hffff, 16'hffff, 8'h90, 8'h01, 1);
    queue_exact(MODE_TICK, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_exact(MODE_TICK, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0);
    queue_drain();

    // Random part. It opens by loading every voice so that wide mixes occur,
    // then runs mostly well-formed loads, triggers and ticks, with stray and
    // ignored beats mixed in, until the whole stream holds about the planned
    // number of beats.
    for (v = 0; v < NUM_VOICES; v++) begin
      k = $urandom_range(1, 10);
      queue_load(v, k);
    end
    while (stim_queue.size() < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        v = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, PADS);
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        queue_load(v, k);
      end else if (pick < 24) begin
        queue_note_on($urandom_range(0, PADS - 1));
      end else if (pick < 32) begin
        b = noise_beat(MODE_RESTART);
        add_beat(b);
      end else if (pick < 34) begin
        // Every pad at once, which drives the voice count toward its top.
        for (k = 0; k < PADS; k++) queue_note_on(k);
      end else if (pick < 75) begin
        add_beat(noise_beat(MODE_TICK));
      end else if (pick < 80) begin
        b = noise_beat(MODE_MIDI);
        add_beat(b);
      end else if (pick < 85) begin
        // Frames or an end with no begin ahead of them.
        b       = noise_beat((pick < 83) ? MODE_FRAME : MODE_END);
        b.voice = 6'($urandom_range(0, PADS));
        b.left  = pick_sample();
        b.right = pick_sample();
        add_beat(b);
      end else if (pick < 90) begin
        b       = noise_beat(3'($urandom_range(MODE_BEGIN, MODE_END)));
        b.voice = 6'($urandom_range(NUM_VOICES, 63));
        add_beat(b);
      end else if (pick < 93) begin
        add_beat(noise_beat((pick < 92) ? MODE_SPARE_A : MODE_SPARE_B));
      end else if (pick < 96) begin
        b       = noise_beat(MODE_BEGIN);
        b.voice = 6'($urandom_range(0, PADS));
        add_beat(b);
      end else if (pick < 97) begin
        queue_drain();
      end else begin
        add_beat(noise_beat(MODE_TICK));
      end
    end
    queue_drain();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every beat is taken and every mix has come back, then give
    // the block time to show any stray result.
    while (stim_queue.size() != 0 || beats_taken != beats_sent || mix_queue.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
